>>> sv/dscf_pkg.sv
// Shared types, constants and fixed-point helpers for the damped spring chain follower.
// Used by dscf_lane and damped_spring_chain_follower; depends on nothing else.
package dscf_pkg;

  // Chain size and field widths.
  localparam int NUM_ELEMENTS_DEF = 16;
  localparam int ELEM_W           = 6;
  localparam int COORD_W          = 16;
  localparam int FRAC_W           = 16;
  localparam int Q_W              = 32;
  localparam int CFG_W            = 16;
  localparam int CFG_INDEX_W      = 4;
  localparam int GAIN_W           = CFG_W + ELEM_W;
  localparam int DAMP_W           = 16;

  // Internal arithmetic widths.
  localparam int DELTA_W     = Q_W + 1;
  localparam int PULL_PROD_W = DELTA_W + GAIN_W + 1;
  localparam int PULL_W      = PULL_PROD_W + 1 - FRAC_W;
  localparam int DAMP_PROD_W = Q_W + DAMP_W + 1;
  localparam int DAMP_RND_W  = DAMP_PROD_W + 1 - FRAC_W;
  localparam int SAT_IN_W    = PULL_W + 1;
  localparam int RND_HALF    = 32768;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING   = CFG_INDEX_W'(1);
  localparam logic [CFG_W-1:0]       STIFFNESS_RST = CFG_W'(3277);
  localparam logic [CFG_W-1:0]       DAMPING_RST   = CFG_W'(58982);
  // 0.02 in Q0.16, rounded to nearest.
  localparam logic [CFG_W:0]         DAMP_DECREMENT = 17'd1311;

  typedef logic signed [Q_W-1:0] q16_t;

  // Stage strobes from the sequencer to each coordinate lane.
  typedef struct packed {
    logic delta_en;
    logic mul_en;
    logic vel_en;
    logic pos_en;
    logic first;
  } dscf_ctrl_t;

  // Saturate a wide signed value to the Q16.16 range.
  function automatic q16_t sat_q16(input logic signed [SAT_IN_W-1:0] v);
    q16_t r;
    if (v[SAT_IN_W-1:Q_W-1] == '0 || v[SAT_IN_W-1:Q_W-1] == '1) begin
      r = v[Q_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Scale the pull product down by 2^16, round to nearest, ties up.
  function automatic logic signed [PULL_W-1:0] round_pull(
    input logic signed [PULL_PROD_W-1:0] p);
    logic signed [PULL_PROD_W:0] s;
    s = (PULL_PROD_W+1)'(p) + (PULL_PROD_W+1)'(RND_HALF);
    return s[PULL_PROD_W:FRAC_W];
  endfunction

  // Scale the damping product down by 2^16, round to nearest, ties up.
  function automatic logic signed [DAMP_RND_W-1:0] round_damp(
    input logic signed [DAMP_PROD_W-1:0] p);
    logic signed [DAMP_PROD_W:0] s;
    s = (DAMP_PROD_W+1)'(p) + (DAMP_PROD_W+1)'(RND_HALF);
    return s[DAMP_PROD_W:FRAC_W];
  endfunction

endpackage

>>> sv/dscf_lane.sv
// One coordinate lane of the chain update: delta, pull multiply, velocity, position, damping.
// Depends on dscf_pkg; the sequencer in the top level drives its stage strobes.
module dscf_lane (
  input  logic                          clk,
  input  dscf_pkg::dscf_ctrl_t          ctrl,
  input  dscf_pkg::q16_t                target,
  input  dscf_pkg::q16_t                rd_pos,
  input  dscf_pkg::q16_t                rd_vel,
  input  logic [dscf_pkg::GAIN_W-1:0]   gain,
  input  logic [dscf_pkg::DAMP_W-1:0]   damp,
  output dscf_pkg::q16_t                pos_new,
  output dscf_pkg::q16_t                vel_new
);
  import dscf_pkg::*;

  logic signed [DELTA_W-1:0]     delta_r;
  logic signed [PULL_PROD_W-1:0] prod_r;
  logic signed [DAMP_PROD_W-1:0] dprod_r;
  q16_t                          pos_old_r;
  q16_t                          vel_old_r;
  q16_t                          vel_r;
  q16_t                          pos_r;
  q16_t                          anchor;
  logic signed [SAT_IN_W-1:0]    vel_sum;
  logic signed [SAT_IN_W-1:0]    pos_sum;

  // Element 0 follows the target; later elements follow the element just updated.
  assign anchor  = ctrl.first ? target : pos_r;
  assign vel_sum = SAT_IN_W'(vel_old_r) + SAT_IN_W'(round_pull(prod_r));
  assign pos_sum = SAT_IN_W'(pos_old_r) + SAT_IN_W'(vel_r);

  // One register stage per step of the element update.
  always_ff @(posedge clk) begin
    if (ctrl.delta_en) begin
      delta_r   <= DELTA_W'(anchor) - DELTA_W'(rd_pos);
      pos_old_r <= rd_pos;
      vel_old_r <= rd_vel;
    end
    if (ctrl.mul_en) begin
      prod_r <= delta_r * $signed({1'b0, gain});
    end
    if (ctrl.vel_en) begin
      vel_r <= sat_q16(vel_sum);
    end
    if (ctrl.pos_en) begin
      pos_r   <= sat_q16(pos_sum);
      dprod_r <= vel_r * $signed({1'b0, damp});
    end
  end

  // Damped velocity is rounded and saturated on its way to the write port.
  assign pos_new = pos_r;
  assign vel_new = sat_q16(SAT_IN_W'(round_damp(dprod_r)));

endmodule

>>> sv/damped_spring_chain_follower.sv
// Each accepted item is a target point; the block then emits one result per chain element,
// element 0 first, with last set on element NUM_ELEMENTS-1. Positions and velocities live in
// two on-chip memories of NUM_ELEMENTS entries, and every element goes through a read, modify
// and write-back sequence (delta, pull multiply, velocity, position with the damping multiply,
// write-back); the element chain is walked one element at a time because each element
// follows the position its predecessor has just taken. The next item is accepted only after
// the last element of the current one is written back, and a write-back waits while the
// output is held by out_ready. Memory entries read as zero until first written; no clearing
// pass is needed after reset. The configuration channel is always ready, but registers should
// only be written while the block is idle, since the gains feed the element in progress.
module damped_spring_chain_follower #(
  parameter int NUM_ELEMENTS = dscf_pkg::NUM_ELEMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dscf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dscf_pkg::CFG_W-1:0]          cfg_data,
  // Target input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dscf_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [dscf_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [dscf_pkg::COORD_W-1:0] in_target_z,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dscf_pkg::ELEM_W-1:0]         out_element_index,
  output logic signed [dscf_pkg::Q_W-1:0]     out_pos_x,
  output logic signed [dscf_pkg::Q_W-1:0]     out_pos_y,
  output logic signed [dscf_pkg::Q_W-1:0]     out_pos_z,
  output logic                                out_last
);
  import dscf_pkg::*;

  localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_DELTA = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_VEL   = 3'd4;
  localparam logic [2:0] ST_POS   = 3'd5;
  localparam logic [2:0] ST_WVEL  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [ELEM_W-1:0]       idx_r, idx_nxt;
  logic [ELEM_W-1:0]       idx_inc;
  logic [CFG_W-1:0]        stiffness_r;
  logic [CFG_W-1:0]        damping_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [DAMP_W-1:0]       damp_r;
  logic [ELEM_W:0]         elem_num;
  logic [CFG_W:0]          damp_decr;
  q16_t                    target_r [3];
  logic                    last_elem;
  logic                    emit;
  logic                    accept;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [NUM_ELEMENTS-1:0] valid_r;
  logic                    rd_valid_r;
  logic [3*Q_W-1:0]        pos_mem [NUM_ELEMENTS];
  logic [3*Q_W-1:0]        vel_mem [NUM_ELEMENTS];
  logic [3*Q_W-1:0]        pos_rd_r;
  logic [3*Q_W-1:0]        vel_rd_r;
  logic [3*Q_W-1:0]        pos_wdata;
  logic [3*Q_W-1:0]        vel_wdata;
  q16_t                    lane_pos [3];
  q16_t                    lane_vel [3];
  dscf_ctrl_t              ctrl;
  logic                    out_valid_r;
  logic [ELEM_W-1:0]       out_element_index_r;
  q16_t                    out_pos_r [3];
  logic                    out_last_r;

  // Handshake decode.
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign idx_inc   = idx_r + ELEM_W'(1);
  assign last_elem = (idx_r == ELEM_W'(NUM_ELEMENTS - 1));
  assign emit      = (state_r == ST_WVEL) && (!out_valid_r || out_ready);

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= STIFFNESS_RST;
      damping_r   <= DAMPING_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STIFFNESS: stiffness_r <= cfg_data;
        REG_DAMPING:   damping_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-element gain and damping, registered from the element counter.
  assign elem_num  = {1'b0, idx_r} + (ELEM_W+1)'(1);
  assign damp_decr = DAMP_DECREMENT * (CFG_W+1)'(idx_r);

  always_ff @(posedge clk) begin
    gain_r <= GAIN_W'(stiffness_r) * GAIN_W'(elem_num);
    if (damp_decr > {1'b0, damping_r}) begin
      damp_r <= '0;
    end else begin
      damp_r <= DAMP_W'({1'b0, damping_r} - damp_decr);
    end
  end

  // Sequencer: one element at a time, read, update and write back.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
          idx_nxt   = '0;
        end
      end
      ST_READ:  state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_VEL;
      ST_VEL:   state_nxt = ST_POS;
      ST_POS:   state_nxt = ST_WVEL;
      ST_WVEL: begin
        if (emit) begin
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DELTA;
            idx_nxt   = idx_inc;
          end
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Target capture in Q16.16.
  always_ff @(posedge clk) begin
    if (accept) begin
      target_r[0] <= {in_target_x, {FRAC_W{1'b0}}};
      target_r[1] <= {in_target_y, {FRAC_W{1'b0}}};
      target_r[2] <= {in_target_z, {FRAC_W{1'b0}}};
    end
  end

  // The next element is read during the write-back of the current one; the two
  // addresses differ whenever a next element is read, so no forwarding is needed.
  assign rd_addr = (state_r == ST_WVEL && !last_elem) ? idx_inc[AW-1:0] : idx_r[AW-1:0];
  assign wr_addr = idx_r[AW-1:0];

  // Written flags: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (emit) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Position and velocity memories, one entry per element, three coordinates wide.
  assign pos_wdata = {lane_pos[2], lane_pos[1], lane_pos[0]};
  assign vel_wdata = {lane_vel[2], lane_vel[1], lane_vel[0]};

  always_ff @(posedge clk) begin
    if (emit) begin
      pos_mem[wr_addr] <= pos_wdata;
      vel_mem[wr_addr] <= vel_wdata;
    end
    pos_rd_r <= pos_mem[rd_addr];
    vel_rd_r <= vel_mem[rd_addr];
  end

  // Stage strobes for the coordinate lanes.
  always_comb begin
    ctrl.delta_en = (state_r == ST_DELTA);
    ctrl.mul_en   = (state_r == ST_MUL);
    ctrl.vel_en   = (state_r == ST_VEL);
    ctrl.pos_en   = (state_r == ST_POS);
    ctrl.first    = (idx_r == '0);
  end

  // Three coordinate lanes.
  for (genvar c = 0; c < 3; c++) begin : g_lane
    q16_t rd_pos;
    q16_t rd_vel;
    assign rd_pos = rd_valid_r ? pos_rd_r[c*Q_W +: Q_W] : '0;
    assign rd_vel = rd_valid_r ? vel_rd_r[c*Q_W +: Q_W] : '0;

    dscf_lane u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .target  (target_r[c]),
      .rd_pos  (rd_pos),
      .rd_vel  (rd_vel),
      .gain    (gain_r),
      .damp    (damp_r),
      .pos_new (lane_pos[c]),
      .vel_new (lane_vel[c])
    );
  end

  // Output register: loaded when empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_element_index_r <= idx_r;
      out_pos_r[0]        <= lane_pos[0];
      out_pos_r[1]        <= lane_pos[1];
      out_pos_r[2]        <= lane_pos[2];
      out_last_r          <= last_elem;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_element_index = out_element_index_r;
  assign out_pos_x         = out_pos_r[0];
  assign out_pos_y         = out_pos_r[1];
  assign out_pos_z         = out_pos_r[2];
  assign out_last          = out_last_r;

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WVEL && out_valid_r && !out_ready) |=> (state_r == ST_WVEL))
    else $error("result loaded over a waiting result");

  // Elements are emitted in order, one step at a time.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last_elem) |=> (idx_r == $past(idx_inc) && state_r == ST_DELTA))
    else $error("element index did not advance by one");

  // An accepted item starts at element zero.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_READ && idx_r == '0))
    else $error("item did not start at element zero");

  // The element counter stays inside the chain.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} < (ELEM_W+1)'(NUM_ELEMENTS))
    else $error("element counter out of range");

endmodule
